// ===== design/dfwa_pkg.sv =====
// Shared types and constants for the decimal fixed-width ALU.
package dfwa_pkg;

  localparam int unsigned MaxDigits = 16;
  localparam int unsigned WordW = 4 * MaxDigits;
  localparam int unsigned ScalarW = 32;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_ADDS = 3'd3,
    CMD_SUBS = 3'd4,
    CMD_MULS = 3'd5,
    CMD_NOP6 = 3'd6,
    CMD_NOP7 = 3'd7
  } cmd_t;

  // Stage-1 register: the operation, both operands and the scalar.
  typedef struct packed {
    cmd_t              cmd;
    logic [WordW-1:0]  a;
    logic [WordW-1:0]  b;
    logic signed [ScalarW-1:0] k;
  } op_t;

endpackage

// ===== design/dfwa_lane.sv =====
// One digit lane: the binary value that this operation adds at weight 10^LANE.
module dfwa_lane #(
  parameter int unsigned LANE   = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  dfwa_pkg::op_t           op,
  output logic signed [39:0]      term
);
  import dfwa_pkg::*;

  logic signed [39:0] term_next;
  logic [3:0]         da;
  logic [3:0]         db;
  logic [11:0]        conv;

  assign da = op.a[4*LANE +: 4];

  // Digit convolution: one small product per pair, summed in a flat tree.
  always_comb begin
    conv = '0;
    for (int e = 0; e <= int'(LANE); e++) begin
      db   = op.b[4*(int'(LANE)-e) +: 4];
      conv = conv + 12'(op.a[4*e +: 4]) * 12'(db);
    end
  end

  always_comb begin
    term_next = '0;
    unique case (op.cmd)
      CMD_ADD:  term_next = 40'(da) + 40'(op.b[4*LANE +: 4]);
      CMD_SUB:  term_next = 40'(da) - 40'(op.b[4*LANE +: 4]);
      CMD_MUL:  term_next = 40'(conv);
      CMD_ADDS: term_next = (LANE == 0) ? 40'(da) + 40'(op.k) : 40'(da);
      CMD_SUBS: term_next = (LANE == 0) ? 40'(da) - 40'(op.k) : 40'(da);
      CMD_MULS: term_next = $signed({36'd0, da}) * 40'(op.k);
      default:  term_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term <= term_next;
    end
  end

endmodule

// ===== design/dfwa_merge.sv =====
// Carry stage: normalize lane sums base ten, two register steps per digit, drop overflow.
module dfwa_merge #(
  parameter int unsigned DIGITS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [39:0]     terms [DIGITS],
  output logic [4*DIGITS-1:0]    digits
);
  import dfwa_pkg::*;

  // Offset that lifts every digit sum to a nonnegative value; ten times 2^32.
  localparam logic [39:0]        Bias      = 40'd42949672960;
  // The same offset seen after the division by ten.
  localparam logic signed [39:0] CarryBias = 40'sd4294967296;

  // Quotient by ten from a shift-add reciprocal; at most one low.
  function automatic logic [39:0] div10_est(logic [39:0] x);
    logic [39:0] q;
    q = (x >> 1) + (x >> 2);
    q = q + (q >> 4);
    q = q + (q >> 8);
    q = q + (q >> 16);
    q = q + (q >> 32);
    return q >> 3;
  endfunction

  logic signed [39:0]  carry [DIGITS];
  logic signed [39:0]  tq    [2*DIGITS-1][DIGITS];
  logic [4*DIGITS-1:0] dq    [2*DIGITS+1];

  assign carry[0] = '0;
  assign dq[0]    = '0;
  assign tq[0]    = terms;

  for (genvar d = 0; d < DIGITS; d++) begin : g_dig
    logic [39:0]         u_next;
    logic [39:0]         u_q;
    logic [39:0]         q_q;
    logic [39:0]         rem;
    logic [4*DIGITS-1:0] da_q;
    logic [4*DIGITS-1:0] d_next;
    logic [4*DIGITS-1:0] db_q;

    // First step: biased digit sum and the quotient estimate.
    assign u_next = 40'(tq[2*d][d]) + 40'(carry[d]) + Bias;

    always_ff @(posedge clk) begin
      if (en) begin
        u_q  <= u_next;
        q_q  <= div10_est(u_next);
        da_q <= dq[2*d];
      end
    end
    assign dq[2*d+1] = da_q;

    // Second step: fix the estimate, emit the digit.
    assign rem = u_q - ((q_q << 3) + (q_q << 1));

    always_comb begin
      d_next = da_q;
      d_next[4*d +: 4] = (rem > 40'd9) ? 4'(rem - 40'd10) : 4'(rem);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        db_q <= d_next;
      end
    end
    assign dq[2*d+2] = db_q;

    // Carry and remaining sums go on to the next digit; the top carry is dropped.
    if (d + 1 < DIGITS) begin : g_carry
      logic [39:0]        q_fix;
      logic signed [39:0] c_q;
      logic signed [39:0] ta_q [DIGITS];
      logic signed [39:0] tb_q [DIGITS];

      assign q_fix = (rem > 40'd9) ? q_q + 40'd1 : q_q;

      always_ff @(posedge clk) begin
        if (en) begin
          ta_q <= tq[2*d];
          tb_q <= tq[2*d+1];
          c_q  <= $signed(q_fix) - CarryBias;
        end
      end
      assign tq[2*d+1]  = ta_q;
      assign tq[2*d+2]  = tb_q;
      assign carry[d+1] = c_q;
    end
  end

  assign digits = dq[2*DIGITS];

endmodule

// ===== design/decimal_fixed_width_alu_core.sv =====
// Top level of the decimal fixed-width ALU: input stage, digit lanes, carry merge.
//
// Usage: present command, operand_a, operand_b and scalar with valid; the item
// is taken when valid and ready are both high. One result item per input item
// comes out on result with result_valid/result_ready, in order.
// Operands are packed BCD of DIGITS digits; nibbles 10..15 count as digit
// values. Results are normalized BCD modulo 10^DIGITS, negatives as ten's
// complement, upper nibbles zero. Commands 6 and 7 give zero.
// Pipeline: from accept to result valid the item passes through
// one input register, one lane register, then two register steps per digit in
// the carry merge (quotient estimate, then correction and carry out).
// Throughput: one item per cycle while the receiver does not stall; the whole pipe advances together.
// The lanes each form one digit position's binary sum and register it.
// When the receiver stalls with a result waiting, every stage holds and ready
// drops in the same cycle; ready is high whenever the last stage is empty or
// its item is being taken.
// Reset clears all valid bits; data registers are not reset.
module decimal_fixed_width_alu_core #(
  parameter int unsigned DIGITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               valid,
  output logic                               ready,
  input  logic [2:0]                         command,
  input  logic [63:0]                        operand_a,
  input  logic [63:0]                        operand_b,
  input  logic signed [31:0]                 scalar,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [63:0]                        result
);
  import dfwa_pkg::*;

  localparam int unsigned Depth = 2 + 2 * DIGITS;
  localparam logic [63:0] DigitMask = 64'((65'd1 << (4 * DIGITS)) - 65'd1);

  logic [Depth-1:0] vld;
  op_t              op;
  logic signed [39:0] terms [DIGITS];
  logic [4*DIGITS-1:0] digits;

  // Advance every stage together unless a result waits on a stalled receiver.
  logic en;
  assign en    = !vld[Depth-1] || result_ready;
  assign ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], valid};
    end
  end

  // Capture the item, masking nibbles above DIGITS.
  always_ff @(posedge clk) begin
    if (en) begin
      op.cmd   <= cmd_t'(command);
      op.a     <= operand_a & DigitMask;
      op.b     <= operand_b & DigitMask;
      op.k     <= scalar;
    end
  end

  for (genvar l = 0; l < DIGITS; l++) begin : g_lane
    dfwa_lane #(.LANE(l)) u_lane (
      .clk  (clk),
      .en   (en),
      .op   (op),
      .term (terms[l])
    );
  end

  dfwa_merge #(.DIGITS(DIGITS)) u_merge (
    .clk    (clk),
    .en     (en),
    .terms  (terms),
    .digits (digits)
  );

  assign result_valid = vld[Depth-1];
  assign result       = 64'(digits);

`ifndef SYNTH
  // A stalled result must hold its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result))
    else $error("result changed while stalled");
  // Accepted input implies pipe head marked valid next cycle.
  a_head: assert property (@(posedge clk) disable iff (rst)
    valid && ready |=> vld[0])
    else $error("accepted item lost at pipe head");
  // The lowest result digit is always normalized decimal.
  a_bcd: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result[3:0] <= 4'd9))
    else $error("unnormalized result digit");
`endif

endmodule

// ===== dv/decimal_fixed_width_alu_core_tb.sv =====
// Self-checking testbench for the decimal fixed-width ALU core.
module decimal_fixed_width_alu_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dfwa_pkg::*;

  localparam int unsigned NumDigits = 16;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 200;
  localparam logic [63:0] AllNines = 64'h9999_9999_9999_9999;
  localparam logic [63:0] AllF = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic [2:0] command = '0;
  logic [63:0] operand_a = '0;
  logic [63:0] operand_b = '0;
  logic signed [31:0] scalar = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [63:0] result;

  // Results still owed by the block, oldest first.
  logic [63:0] pending_sums[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  // Idle and stall odds in percent, changed per phase.
  int unsigned snd_idle = 0;
  int unsigned rcv_stall = 0;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;

  decimal_fixed_width_alu_core #(
    .DIGITS(NumDigits)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .valid(valid),
    .ready(ready),
    .command(command),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .scalar(scalar),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Decimal value of the operation, wrapped to NumDigits digits.
  function automatic logic [63:0] decimal_result(cmd_t op, logic [63:0] a, logic [63:0] b,
                                                 logic signed [31:0] k);
    longint da[NumDigits];
    longint db[NumDigits];
    longint acc[NumDigits];
    longint v;
    longint q;
    logic [63:0] w;
    w = '0;
    for (int d = 0; d < NumDigits; d++) begin
      da[d] = longint'(a[4*d +: 4]);
      db[d] = longint'(b[4*d +: 4]);
      acc[d] = 0;
    end
    case (op)
      CMD_ADD: for (int d = 0; d < NumDigits; d++) acc[d] = da[d] + db[d];
      CMD_SUB: for (int d = 0; d < NumDigits; d++) acc[d] = da[d] - db[d];
      CMD_MUL: begin
        for (int d = 0; d < NumDigits; d++)
          for (int e = 0; d + e < NumDigits; e++) acc[d+e] += da[d] * db[e];
      end
      CMD_ADDS: begin
        acc = da;
        acc[0] += longint'(k);
      end
      CMD_SUBS: begin
        acc = da;
        acc[0] -= longint'(k);
      end
      CMD_MULS: for (int d = 0; d < NumDigits; d++) acc[d] = da[d] * longint'(k);
      default: ;
    endcase
    // Floor carry upward; carry out of the top digit is lost.
    for (int d = 0; d < NumDigits; d++) begin
      v = acc[d];
      if (v >= 10) q = v / 10;
      else if (v < 0) q = -((-v - 1) / 10 + 1);
      else q = 0;
      w[4*d +: 4] = 4'(v - q * 10);
      if (d + 1 < NumDigits) acc[d+1] += q;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    err_count++;
  endtask

  // Offer one item; return at the edge where it is taken.
  task automatic send_item(cmd_t op, logic [63:0] a, logic [63:0] b, logic signed [31:0] k,
                           bit known, logic [63:0] known_res);
    while ($urandom_range(99) < snd_idle) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1;
    command <= op;
    operand_a <= a;
    operand_b <= b;
    scalar <= k;
    do @(negedge clk); while (!ready);
    @(posedge clk);
    pending_sums.push_back(known ? known_res : decimal_result(op, a, b, k));
  endtask

  // Operand mix: clean BCD, raw bits, extremes, small binary values, BCD with one bad nibble.
  function automatic logic [63:0] pick_word();
    logic [63:0] w;
    w = '0;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: for (int d = 0; d < NumDigits; d++) w[4*d +: 4] = 4'($urandom_range(9));
      5, 6: w = {$urandom, $urandom};
      7: w = ($urandom_range(1) != 0) ? AllNines : AllF;
      8: w = 64'($urandom_range(99));
      default: begin
        for (int d = 0; d < NumDigits; d++) w[4*d +: 4] = 4'($urandom_range(9));
        w[4*$urandom_range(NumDigits-1) +: 4] = 4'($urandom_range(15, 10));
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [31:0] pick_scalar();
    case ($urandom_range(5))
      0, 1: return $signed(32'($urandom_range(19))) - 32'sd9;
      2: return $signed($urandom);
      3: return ($urandom_range(1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed(32'($urandom_range(2000))) - 32'sd1000;
    endcase
  endfunction

  task automatic send_random(int unsigned count);
    cmd_t op;
    for (int unsigned n = 0; n < count; n++) begin
      op = ($urandom_range(19) == 0) ? cmd_t'($urandom_range(7, 6)) : cmd_t'($urandom_range(5));
      send_item(op, pick_word(), pick_word(), pick_scalar(), 1'b0, '0);
    end
  endtask

  typedef struct {
    cmd_t op;
    logic [63:0] a;
    logic [63:0] b;
    logic signed [31:0] k;
    bit known;
    logic [63:0] res;
  } plan_row_t;

  // Directed rows: extremes, every command, bad nibbles, unused operands, no-op codes.
  plan_row_t plan[20] = '{
    '{CMD_ADD, 64'h0, 64'h0, 32'sd0, 1'b1, 64'h0},
    '{CMD_ADD, AllNines, 64'h1, 32'sd0, 1'b1, 64'h0},
    '{CMD_SUB, 64'h0, 64'h1, 32'sd0, 1'b1, AllNines},
    '{CMD_MUL, AllNines, 64'h1, 32'sd0, 1'b1, AllNines},
    '{CMD_ADDS, 64'h0, AllF, -32'sd1, 1'b1, AllNines},
    '{CMD_SUBS, 64'h0, AllF, 32'sd1, 1'b1, AllNines},
    '{CMD_MULS, AllNines, AllF, 32'sd0, 1'b1, 64'h0},
    '{CMD_NOP6, AllF, AllF, -32'sd1, 1'b1, 64'h0},
    '{CMD_NOP7, AllNines, AllF, 32'sh7FFF_FFFF, 1'b1, 64'h0},
    '{CMD_ADD, AllF, AllF, 32'sd5, 1'b0, 64'h0},
    '{CMD_SUB, 64'h0, AllF, 32'sd0, 1'b0, 64'h0},
    '{CMD_MUL, AllF, AllF, 32'sd0, 1'b0, 64'h0},
    '{CMD_MUL, AllNines, AllNines, 32'sd3, 1'b0, 64'h0},
    '{CMD_ADDS, AllNines, AllF, 32'sh7FFF_FFFF, 1'b0, 64'h0},
    '{CMD_ADDS, 64'h0, 64'h0, 32'sh8000_0000, 1'b0, 64'h0},
    '{CMD_SUBS, AllF, 64'h0, 32'sh8000_0000, 1'b0, 64'h0},
    '{CMD_SUBS, 64'h1234, 64'h0, 32'sh7FFF_FFFF, 1'b0, 64'h0},
    '{CMD_MULS, AllF, 64'h0, 32'sh8000_0000, 1'b0, 64'h0},
    '{CMD_MULS, 64'h0987_6543_2109_8765, AllF, -32'sd7, 1'b0, 64'h0},
    '{CMD_ADD, 64'hA0B0_C0D0_E0F0_0A0B, 64'h0C0D_0E0F_1234_5678, -32'sd1, 1'b0, 64'h0}
  };

  // Receiver side: random stall, or a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  // Check at the falling edge; inputs and outputs are settled by then.
  always @(negedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", result));
      end else begin
        if (result !== pending_sums[0])
          report_mismatch($sformatf("result %h, expected %h", result, pending_sums[0]));
        void'(pending_sums.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows, no idling.
    foreach (plan[i]) send_item(plan[i].op, plan[i].a, plan[i].b, plan[i].k, plan[i].known,
                                plan[i].res);

    send_random(180);
    snd_idle = 87;
    send_random(150);

    // Pause until the block has drained.
    valid <= 1'b0;
    wait (pending_sums.size() == 0);
    @(posedge clk);

    snd_idle = 0;
    rcv_stall = 87;
    send_random(150);

    // Long receiver hold-off while items keep coming, so the pipe fills.
    rcv_stall = 0;
    hold_req = 1'b1;
    send_random(60);

    snd_idle = 13;
    rcv_stall = 13;
    send_random(180);

    valid <= 1'b0;
    wait (pending_sums.size() == 0);
    repeat (30) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dfwa_pkg.sv
design/dfwa_lane.sv
design/dfwa_merge.sv
design/decimal_fixed_width_alu_core.sv
dv/decimal_fixed_width_alu_core_tb.sv
